// File: rtl/core/multi_queue_round_robin_core_assert.svh
// Assertion macros used by the multi-queue round-robin core.
`ifndef MULTI_QUEUE_ROUND_ROBIN_CORE_ASSERT_SVH
`define MULTI_QUEUE_ROUND_ROBIN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MQRR_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MQRR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mqrr_pkg.sv
// Types and codes of the multi-queue round-robin core.
package mqrr_pkg;

   localparam int QIDX_MAX_W = 6;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_TAKE_SEL   = 3'd2,
      OP_TAKE_ANY   = 3'd3,
      OP_PUSH_FIRST = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STS_OK    = 3'd0,
      STS_SHUT  = 3'd1,
      STS_OFF   = 3'd2,
      STS_FULL  = 3'd3,
      STS_EMPTY = 3'd4
   } status_type;

   localparam logic [2:0] CSR_FAIR_MODE     = 3'd0;
   localparam logic [2:0] CSR_SHUT_DOWN     = 3'd1;
   localparam logic [2:0] CSR_ADD_OFF_ALL   = 3'd2;
   localparam logic [2:0] CSR_TAKE_OFF_ALL  = 3'd3;
   localparam logic [2:0] CSR_ADD_OFF_MASK  = 3'd4;
   localparam logic [2:0] CSR_TAKE_OFF_MASK = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  queue_sel;
      logic [31:0] item;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] item_out;
      logic [2:0]  served_queue;
   } rsp_type;

   // Broadcast to every order cell.
   typedef struct packed {
      logic                  move;
      logic [QIDX_MAX_W-1:0] queue;
   } cell_ctl_type;

endpackage

// File: rtl/core/multi_queue_round_robin_core.sv
// A set of FIFO queues in one word memory behind a round-robin arbiter. Each request word
// appends, pushes to the front, takes from a chosen queue, takes from the first non-empty
// queue in service order, or pushes to the front of the first queue in order, and returns
// one response word with a status. The service order lives in a row of cells that search
// for the first non-empty queue and shift a served queue to the back in fair mode. A request
// passes a decide state, which accesses the memory and pointers, then a finish state that
// loads the response register when it is free; the next request is accepted as the response
// loads. No clearing pass after reset; configuration writes are accepted every cycle.
module multi_queue_round_robin_core
   import mqrr_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

`include "multi_queue_round_robin_core_assert.svh"

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 2;
   localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   function automatic logic mask_bit(logic [7:0] mask, logic [QIDX_W-1:0] q);
      logic [6:0] qx;
      qx = 7'(q);
      return (qx < 7'd8) && mask[qx[2:0]];
   endfunction

   // configuration
   logic       fair_ff, shut_ff, add_off_all_ff, take_off_all_ff;
   logic [7:0] add_mask_ff, take_mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fair_ff         <= 1'b0;
         shut_ff         <= 1'b0;
         add_off_all_ff  <= 1'b0;
         take_off_all_ff <= 1'b0;
         add_mask_ff     <= '0;
         take_mask_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FAIR_MODE:     fair_ff         <= csr_data[0];
            CSR_SHUT_DOWN:     shut_ff         <= csr_data[0];
            CSR_ADD_OFF_ALL:   add_off_all_ff  <= csr_data[0];
            CSR_TAKE_OFF_ALL:  take_off_all_ff <= csr_data[0];
            CSR_ADD_OFF_MASK:  add_mask_ff     <= csr_data;
            CSR_TAKE_OFF_MASK: take_mask_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // control
   state_type state_ff, state_in;
   logic      req_accept, rsp_load, dec_active;
   logic      rsp_valid_ff;

   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = req_valid ? ST_DECIDE : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      dec_active = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_DECIDE: dec_active = 1'b1;
         ST_FINISH: req_ready  = rsp_load;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   req_type req_ff;
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
   end

   // queue pointers
   logic [PTR_W-1:0] head_ff [NUM_QUEUES];
   logic [CNT_W-1:0] fill_ff [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] nonempty;

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         nonempty[i] = (fill_ff[i] != '0);
      end
   end

   // service order cells
   cell_ctl_type      cell_ctl;
   logic [QIDX_W-1:0] entries [NUM_QUEUES];
   logic [NUM_QUEUES:0] seen_chain, found_chain;
   logic [NUM_QUEUES-1:0] first_vec;

   assign seen_chain[0]  = 1'b0;
   assign found_chain[0] = 1'b0;

   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_cell
      logic [QIDX_W-1:0] nxt;
      if (g == NUM_QUEUES - 1) begin : g_last
         assign nxt = cell_ctl.queue[QIDX_W-1:0];
      end else begin : g_mid
         assign nxt = entries[g+1];
      end
      mqrr_cell #(
         .QIDX_W    (QIDX_W),
         .NUM_QUEUES(NUM_QUEUES),
         .INDEX     (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .next_entry(nxt),
         .nonempty  (nonempty),
         .seen_in   (seen_chain[g]),
         .found_in  (found_chain[g]),
         .entry     (entries[g]),
         .seen_out  (seen_chain[g+1]),
         .found_out (found_chain[g+1]),
         .first     (first_vec[g])
      );
   end

   logic [QIDX_W-1:0] first_q;
   always_comb begin
      first_q = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         first_q = first_q | (first_vec[i] ? entries[i] : '0);
      end
   end

   // decide
   logic [6:0]        sel_ext;
   logic [QIDX_W-1:0] q_dec;
   logic [2:0]        served;
   status_type        status;
   logic              add_ok, take_ok, front;
   logic [PTR_W-1:0]  head_cur, head_new, slot;
   logic [CNT_W-1:0]  fill_cur;
   logic [SUM_W-1:0]  tail_sum;
   logic [ADDR_W-1:0] addr;

   assign sel_ext = 7'(req_ff.queue_sel);

   always_comb begin
      q_dec  = '0;
      served = '0;
      unique case (req_ff.op)
         OP_APPEND, OP_PUSH_FRONT, OP_TAKE_SEL: begin
            q_dec  = sel_ext[QIDX_W-1:0];
            served = req_ff.queue_sel;
         end
         OP_PUSH_FIRST: begin
            q_dec  = entries[0];
            served = 3'(7'(entries[0]));
         end
         OP_TAKE_ANY: begin
            q_dec  = first_q;
            // report a queue only when a word is actually taken
            served = (found_chain[NUM_QUEUES] && !shut_ff && !take_off_all_ff)
                     ? 3'(7'(first_q)) : 3'd0;
         end
         default: ;
      endcase
   end

   assign head_cur = head_ff[q_dec];
   assign fill_cur = fill_ff[q_dec];
   assign front    = (req_ff.op != OP_APPEND);

   always_comb begin
      status  = STS_OK;
      add_ok  = 1'b0;
      take_ok = 1'b0;
      priority if (shut_ff) begin
         status = STS_SHUT;
      end else if (req_ff.op <= OP_TAKE_SEL && sel_ext >= 7'(NUM_QUEUES)) begin
         status = STS_OFF;
      end else if (req_ff.op == OP_APPEND || req_ff.op == OP_PUSH_FRONT
                   || req_ff.op == OP_PUSH_FIRST) begin
         if (add_off_all_ff || mask_bit(add_mask_ff, q_dec)) begin
            status = STS_OFF;
         end else if (fill_cur >= CNT_W'(QUEUE_DEPTH)) begin
            status = STS_FULL;
         end else begin
            add_ok = 1'b1;
         end
      end else if (req_ff.op == OP_TAKE_SEL) begin
         if (mask_bit(take_mask_ff, q_dec)) begin
            status = STS_OFF;
         end else if (fill_cur == '0) begin
            status = STS_EMPTY;
         end else begin
            take_ok = 1'b1;
         end
      end else if (req_ff.op == OP_TAKE_ANY) begin
         if (take_off_all_ff) begin
            status = STS_OFF;
         end else if (!found_chain[NUM_QUEUES]) begin
            status = STS_EMPTY;
         end else begin
            take_ok = 1'b1;
         end
      end else begin
         status = STS_OFF;
      end
   end

   // slot and new head, wrapped at the queue depth
   always_comb begin
      tail_sum = SUM_W'(head_cur) + SUM_W'(fill_cur);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      head_new = head_cur;
      slot     = head_cur;
      if (add_ok) begin
         if (front) begin
            head_new = (head_cur == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_cur - 1'b1;
            slot     = head_new;
         end else begin
            slot = tail_sum[PTR_W-1:0];
         end
      end else if (take_ok) begin
         head_new = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
      end
   end

   assign addr = ADDR_W'(q_dec) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

   assign cell_ctl.move  = dec_active && take_ok && fair_ff;
   assign cell_ctl.queue = QIDX_MAX_W'(q_dec);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (dec_active && (add_ok || take_ok)) begin
         head_ff[q_dec] <= head_new;
         fill_ff[q_dec] <= add_ok ? fill_cur + 1'b1 : fill_cur - 1'b1;
      end
   end

   // word memory
   logic [DATA_WIDTH-1:0] mem [NUM_QUEUES*QUEUE_DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;
   logic [63:0]           wr_wide, rd_wide;

   assign wr_wide = 64'(req_ff.item);
   assign rd_wide = 64'(rd_ff);

   always_ff @(posedge clock) begin
      if (dec_active && add_ok) begin
         mem[addr] <= wr_wide[DATA_WIDTH-1:0];
      end
      if (dec_active) begin
         rd_ff <= mem[addr];
      end
   end

   // result hold between decide and finish
   status_type res_status_ff;
   logic [2:0] res_served_ff;
   logic       res_take_ff;

   always_ff @(posedge clock) begin
      if (dec_active) begin
         res_status_ff <= status;
         res_served_ff <= served;
         res_take_ff   <= take_ok;
      end
   end

   // response register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.status       <= res_status_ff;
         rsp_ff.item_out     <= res_take_ff ? rd_wide[31:0] : 32'd0;
         rsp_ff.served_queue <= res_served_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MQRR_ASSERT_NEXT(a_accept_decides, clock, reset, req_accept, state_ff == ST_DECIDE, "accepted word did not enter decide")
   `MQRR_ASSERT_NEXT(a_decide_finishes, clock, reset, state_ff == ST_DECIDE, state_ff == ST_FINISH, "decide did not advance to finish")
   `MQRR_ASSERT_SAME(a_single_first, clock, reset, 1'b1, $onehot0(first_vec), "more than one first non-empty cell")
   `MQRR_ASSERT_SAME(a_fill_bound, clock, reset, dec_active, fill_cur <= CNT_W'(QUEUE_DEPTH), "fill count above queue depth")

endmodule

// File: rtl/core/mqrr_cell.sv
// One slot of the service order: holds a queue index and ripples search and shift state.
module mqrr_cell
   import mqrr_pkg::*;
#(
   parameter int QIDX_W     = 3,
   parameter int NUM_QUEUES = 8,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [QIDX_W-1:0]     next_entry,
   input  logic [NUM_QUEUES-1:0] nonempty,
   input  logic                  seen_in,
   input  logic                  found_in,
   output logic [QIDX_W-1:0]     entry,
   output logic                  seen_out,
   output logic                  found_out,
   output logic                  first
);

   logic [QIDX_W-1:0] entry_ff;
   logic [QIDX_W-1:0] entry_in;
   logic              hit;
   logic              busy;

   assign hit       = (entry_ff == ctl.queue[QIDX_W-1:0]);
   assign seen_out  = seen_in | hit;
   assign busy      = nonempty[entry_ff];
   assign first     = busy & ~found_in;
   assign found_out = found_in | busy;
   assign entry     = entry_ff;

   // Shift left from the moved queue onward; the last cell takes the moved queue.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.move && seen_out) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= QIDX_W'(INDEX);
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
